/* rtl/mma_pkg.sv */
// Shared types, constants and helpers of the matrix multiply-accumulate engine.
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

    // Built maximum order of the square matrices
    localparam int MAX_DIM = 16;

    // Field and register widths
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 32;
    localparam int AB_W   = 16;
    localparam int SIZE_W = 5;
    localparam int GAIN_W = 16;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 4;

    // Store geometry
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ORD_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (ORD_W > IDX_W) ? ORD_W : IDX_W;

    // Datapath widths: dot-product sum, shared multiplier product, scaled total
    localparam int SUM_W  = 2 * AB_W + $clog2(MAX_DIM);
    localparam int PROD_W = GAIN_W + SUM_W;
    localparam int TOT_W  = PROD_W + 1;
    localparam int FRAC_DROP = 12;
    localparam int RND_W  = TOT_W - FRAC_DROP;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(16);
    localparam logic [GAIN_W-1:0] ALPHA_RST = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0] BETA_RST  = '0;

    typedef enum logic [1:0] {
        REQ_WR_A    = 2'd0,
        REQ_WR_B    = 2'd1,
        REQ_WR_C    = 2'd2,
        REQ_COMPUTE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ALPHA,
        ST_BETA,
        ST_SUM,
        ST_ROUND
    } t_state;

    typedef struct packed {
        t_req                      req_type;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [ELEM_W-1:0]  elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0]  result_value;
        logic                      saturated;
    } t_out_item;

    typedef struct packed {
        logic [SIZE_W-1:0]         matrix_size;
        logic signed [GAIN_W-1:0]  alpha_gain;
        logic signed [GAIN_W-1:0]  beta_gain;
    } t_cfg;

    // Order in use: zero acts as one, anything above the built maximum is clipped
    function automatic logic [ORD_W-1:0] order_in_use(input logic [SIZE_W-1:0] size);
        logic [ORD_W-1:0] n;
        if (size == '0) begin
            n = ORD_W'(1);
        end else if (int'(size) > MAX_DIM) begin
            n = ORD_W'(MAX_DIM);
        end else begin
            n = ORD_W'(size);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/matrix_multiply_accumulate.sv */
// Matrix multiply-accumulate engine: operand stores, sequencer and shared multiplier.
//
// Usage: the input channel carries request words (write A, write B, write C or
// compute one element). An accepted write stores the element at
// (row, col); writes outside the built store are dropped. A compute for (row, col)
// returns alpha * sum_k A[row][k] * B[k][col] + beta * C[row][col], rounded half
// up to Q16.16 and saturated, on the output channel. A compute outside the order
// in use is dropped and returns no word.
// One shared 16 x SUM_W multiplier runs the n dot-product steps, then the alpha
// and beta scalings. A compute runs its MAC, drain, alpha, beta, sum and rounding
// steps before the result word is loaded into the output register, and the next
// word is taken only once the sequencer is back at idle.
// The input side is not ready while a compute is running.
// A finished word waits in the output register while the receiver stalls; new
// writes are still taken meanwhile, and a following compute holds in its
// rounding step until the register is free.
// Reset clears the sequencer, the output valid flag and the configuration
// (order 16, alpha 1.0, beta 0); store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_accumulate (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire mma_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output mma_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mma_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mma_pkg::DATA_W-1:0]  pwdata,
    output logic      [mma_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int AW = mma_pkg::ADDR_W;

    mma_pkg::t_cfg     cfg;
    mma_pkg::t_state   r_state, n_state;

    // Operand stores
    logic [mma_pkg::AB_W-1:0]   a_mem [mma_pkg::DEPTH];
    logic [mma_pkg::AB_W-1:0]   b_mem [mma_pkg::DEPTH];
    logic [mma_pkg::ELEM_W-1:0] c_mem [mma_pkg::DEPTH];

    logic [mma_pkg::AB_W-1:0]   r_a_rd;
    logic [mma_pkg::AB_W-1:0]   r_b_rd;
    logic [mma_pkg::ELEM_W-1:0] r_c_rd;

    // Per-compute context
    logic [mma_pkg::IDX_W-1:0]  r_row;
    logic [mma_pkg::IDX_W-1:0]  r_col;
    logic [mma_pkg::ORD_W-1:0]  r_n;
    logic [mma_pkg::ORD_W-1:0]  r_k;
    logic                       r_rd_vld;
    logic                       r_prod_vld;

    logic signed [mma_pkg::SUM_W-1:0]  r_sum;
    logic signed [mma_pkg::PROD_W-1:0] r_prod;
    logic signed [mma_pkg::TOT_W-1:0]  r_total;

    logic               r_out_vld;
    mma_pkg::t_out_item r_out;

    // Control decoded from the state
    logic in_acc;
    logic issue;
    logic out_load;
    logic cmp_start;
    logic wr_ok;
    logic in_range;
    logic [mma_pkg::ORD_W-1:0] n_cur;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] c_addr;

    logic signed [mma_pkg::GAIN_W-1:0] op_x;
    logic signed [mma_pkg::SUM_W-1:0]  op_y;
    logic signed [mma_pkg::PROD_W-1:0] prod;

    logic signed [mma_pkg::TOT_W-1:0]  biased;
    logic signed [mma_pkg::RND_W-1:0]  rounded;
    logic [mma_pkg::RND_W-32:0]        rnd_hi;
    logic                              sat_pos;
    logic                              sat_neg;

    mma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Decode the incoming word
    assign in_acc  = i_in_valid && o_in_ready;
    assign n_cur   = mma_pkg::order_in_use(cfg.matrix_size);
    assign wr_ok   = (mma_pkg::CMP_W'(i_in_data.row_index) < mma_pkg::CMP_W'(mma_pkg::MAX_DIM))
                  && (mma_pkg::CMP_W'(i_in_data.col_index) < mma_pkg::CMP_W'(mma_pkg::MAX_DIM));
    assign in_range = (mma_pkg::CMP_W'(i_in_data.row_index) < mma_pkg::CMP_W'(n_cur))
                   && (mma_pkg::CMP_W'(i_in_data.col_index) < mma_pkg::CMP_W'(n_cur));
    assign cmp_start = in_acc && (i_in_data.req_type == mma_pkg::REQ_COMPUTE) && in_range;

    assign wr_addr = AW'(i_in_data.row_index) * AW'(mma_pkg::MAX_DIM)
                   + AW'(i_in_data.col_index);
    assign a_addr  = AW'(r_row) * AW'(mma_pkg::MAX_DIM) + AW'(r_k);
    assign b_addr  = AW'(r_k) * AW'(mma_pkg::MAX_DIM) + AW'(r_col);
    assign c_addr  = AW'(r_row) * AW'(mma_pkg::MAX_DIM) + AW'(r_col);

    // Write the stores on accepted write words
    always_ff @(posedge i_clk) begin
        if (in_acc && wr_ok) begin
            case (i_in_data.req_type)
                mma_pkg::REQ_WR_A: a_mem[wr_addr] <= i_in_data.elem_value[mma_pkg::AB_W-1:0];
                mma_pkg::REQ_WR_B: b_mem[wr_addr] <= i_in_data.elem_value[mma_pkg::AB_W-1:0];
                mma_pkg::REQ_WR_C: c_mem[wr_addr] <= i_in_data.elem_value;
                default: ;
            endcase
        end
    end

    // Read the stores, registered
    always_ff @(posedge i_clk) begin
        r_a_rd <= a_mem[a_addr];
        r_b_rd <= b_mem[b_addr];
        r_c_rd <= c_mem[c_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mma_pkg::ST_IDLE: begin
                if (cmp_start) n_state = mma_pkg::ST_MAC;
            end
            mma_pkg::ST_MAC: begin
                if (r_k == r_n - mma_pkg::ORD_W'(1)) n_state = mma_pkg::ST_DRAIN;
            end
            mma_pkg::ST_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) n_state = mma_pkg::ST_ALPHA;
            end
            mma_pkg::ST_ALPHA: n_state = mma_pkg::ST_BETA;
            mma_pkg::ST_BETA:  n_state = mma_pkg::ST_SUM;
            mma_pkg::ST_SUM:   n_state = mma_pkg::ST_ROUND;
            mma_pkg::ST_ROUND: begin
                if (!r_out_vld || i_out_ready) n_state = mma_pkg::ST_IDLE;
            end
            default: n_state = mma_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer and operand selection for the shared multiplier
    always_comb begin
        o_in_ready = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        op_x       = $signed(r_a_rd);
        op_y       = {{(mma_pkg::SUM_W - mma_pkg::AB_W){r_b_rd[mma_pkg::AB_W-1]}}, r_b_rd};
        case (r_state)
            mma_pkg::ST_IDLE:  o_in_ready = 1'b1;
            mma_pkg::ST_MAC:   issue = 1'b1;
            mma_pkg::ST_ALPHA: begin
                op_x = cfg.alpha_gain;
                op_y = r_sum;
            end
            mma_pkg::ST_BETA: begin
                op_x = cfg.beta_gain;
                op_y = {{(mma_pkg::SUM_W - mma_pkg::ELEM_W){r_c_rd[mma_pkg::ELEM_W-1]}},
                        r_c_rd};
            end
            mma_pkg::ST_ROUND: out_load = !r_out_vld || i_out_ready;
            default: ;
        endcase
    end

    assign prod = op_x * op_y;

    // Advance the sequencer and the read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mma_pkg::ST_IDLE;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    // Latch the compute context and walk k
    always_ff @(posedge i_clk) begin
        if (cmp_start) begin
            r_row <= i_in_data.row_index;
            r_col <= i_in_data.col_index;
            r_n   <= n_cur;
            r_k   <= '0;
        end else if (issue) begin
            r_k   <= r_k + mma_pkg::ORD_W'(1);
        end
    end

    // Multiply, accumulate and scale
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (cmp_start) begin
            r_sum <= '0;
        end else if (r_prod_vld) begin
            r_sum <= r_sum + $signed(r_prod[mma_pkg::SUM_W-1:0]);
        end
        if (r_state == mma_pkg::ST_BETA) begin
            r_total <= {r_prod[mma_pkg::PROD_W-1], r_prod};
        end else if (r_state == mma_pkg::ST_SUM) begin
            r_total <= r_total + {r_prod[mma_pkg::PROD_W-1], r_prod};
        end
    end

    // Round half up to Q16.16 and clip to 32 bits
    assign biased  = r_total + mma_pkg::TOT_W'(2048);
    assign rounded = biased[mma_pkg::TOT_W-1:mma_pkg::FRAC_DROP];
    assign rnd_hi  = rounded[mma_pkg::RND_W-1:31];
    assign sat_pos = !rnd_hi[mma_pkg::RND_W-32] && (|rnd_hi);
    assign sat_neg = rnd_hi[mma_pkg::RND_W-32] && !(&rnd_hi);

    // Hold the result word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.saturated <= sat_pos || sat_neg;
            if (sat_pos) begin
                r_out.result_value <= 32'sh7FFF_FFFF;
            end else if (sat_neg) begin
                r_out.result_value <= 32'sh8000_0000;
            end else begin
                r_out.result_value <= rounded[31:0];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Pipeline is empty whenever the sequencer is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_IDLE) |-> (!r_rd_vld && !r_prod_vld))
        else $error("read pipeline busy while idle");

    // The dot-product index never passes the order in use
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_MAC) |-> (r_k < r_n))
        else $error("dot-product index out of range");

    // A new result word only comes from the rounding step
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == mma_pkg::ST_ROUND))
        else $error("result word loaded outside rounding step");

    // An in-range compute starts the dot-product walk
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_start |=> (r_state == mma_pkg::ST_MAC && r_k == '0))
        else $error("compute did not start");

    // A clipped result sits at one end of the range
    a_sat_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.saturated) |->
            (r_out.result_value == 32'sh7FFF_FFFF || r_out.result_value == 32'sh8000_0000))
        else $error("saturated flag without clipped value");

endmodule
`default_nettype wire

/* rtl/mma_regs.sv */
// Configuration register bank of the matrix multiply-accumulate engine.
`timescale 1ns / 1ps
`default_nettype none
module mma_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mma_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mma_pkg::DATA_W-1:0]  pwdata,
    output logic      [mma_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output mma_pkg::t_cfg                    o_cfg
);

    logic [mma_pkg::SIZE_W-1:0] r_size;
    logic [mma_pkg::GAIN_W-1:0] r_alpha;
    logic [mma_pkg::GAIN_W-1:0] r_beta;
    logic [1:0]                 reg_sel;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= mma_pkg::SIZE_RST;
            r_alpha <= mma_pkg::ALPHA_RST;
            r_beta  <= mma_pkg::BETA_RST;
        end else if (wr_en) begin
            case (reg_sel)
                mma_pkg::REG_SIZE:  r_size  <= pwdata[mma_pkg::SIZE_W-1:0];
                mma_pkg::REG_ALPHA: r_alpha <= pwdata[mma_pkg::GAIN_W-1:0];
                mma_pkg::REG_BETA:  r_beta  <= pwdata[mma_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            mma_pkg::REG_SIZE:  prdata = mma_pkg::DATA_W'(r_size);
            mma_pkg::REG_ALPHA: prdata = mma_pkg::DATA_W'(r_alpha);
            mma_pkg::REG_BETA:  prdata = mma_pkg::DATA_W'(r_beta);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.matrix_size = r_size;
    assign o_cfg.alpha_gain  = r_alpha;
    assign o_cfg.beta_gain   = r_beta;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench of the matrix multiply-accumulate engine: stimulus, predictor, checker.
`timescale 1ns / 1ps
module tb_top;

    localparam int     HALF_PERIOD = 10;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_OFF_LEN = 600;
    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    logic                             i_clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    mma_pkg::t_in_item                in_word = '0;
    logic                             out_ready = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [mma_pkg::PADDR_W-1:0]      paddr = '0;
    logic [mma_pkg::DATA_W-1:0]       pwdata = '0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    mma_pkg::t_out_item               o_out_data;
    logic [mma_pkg::DATA_W-1:0]       prdata;
    logic                             pready;

    // Request words waiting for the driver, and results predicted but not yet seen
    mma_pkg::t_in_item                request_queue[$];
    mma_pkg::t_out_item               c_elem_queue[$];

    // Shadow of the configuration and of the operand stores, kept at acceptance
    mma_pkg::t_cfg                    cfg_shadow = '{matrix_size: mma_pkg::SIZE_RST,
                                                     alpha_gain: mma_pkg::ALPHA_RST,
                                                     beta_gain: mma_pkg::BETA_RST};
    logic signed [mma_pkg::AB_W-1:0]   a_store[mma_pkg::DEPTH];
    logic signed [mma_pkg::AB_W-1:0]   b_store[mma_pkg::DEPTH];
    logic signed [mma_pkg::ELEM_W-1:0] c_store[mma_pkg::DEPTH];

    // Which entries the generator has already loaded, so no compute reads a blank one
    bit                  a_loaded[mma_pkg::DEPTH];
    bit                  b_loaded[mma_pkg::DEPTH];
    bit                  c_loaded[mma_pkg::DEPTH];
    int                  gen_order = mma_pkg::MAX_DIM;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  hold_left = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    matrix_multiply_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Order in use: zero counts as one, oversize clips to the built maximum
    function automatic int order_of(input logic [mma_pkg::SIZE_W-1:0] size);
        if (size == '0) begin
            return 1;
        end else if (int'(size) > mma_pkg::MAX_DIM) begin
            return mma_pkg::MAX_DIM;
        end
        return int'(size);
    endfunction

    // Alpha times the row-column dot product plus beta times C, rounded half up and clipped
    function automatic mma_pkg::t_out_item gemm_element(input int row, input int col);
        longint             dot;
        longint             total;
        longint             rounded;
        int                 n;
        mma_pkg::t_out_item r;
        n = order_of(cfg_shadow.matrix_size);
        dot = 0;
        for (int k = 0; k < n; k++) begin
            dot += longint'(a_store[row * mma_pkg::MAX_DIM + k])
                 * longint'(b_store[k * mma_pkg::MAX_DIM + col]);
        end
        total = longint'(cfg_shadow.alpha_gain) * dot
              + longint'(cfg_shadow.beta_gain)
              * longint'(c_store[row * mma_pkg::MAX_DIM + col]);
        rounded = (total + 2048) >>> mma_pkg::FRAC_DROP;
        r.saturated = 1'b0;
        if (rounded > Q_MAX) begin
            r.result_value = 32'sh7FFF_FFFF;
            r.saturated = 1'b1;
        end else if (rounded < Q_MIN) begin
            r.result_value = 32'sh8000_0000;
            r.saturated = 1'b1;
        end else begin
            r.result_value = rounded[mma_pkg::ELEM_W-1:0];
        end
        return r;
    endfunction

    // Apply one accepted word: store an element or predict a result
    task automatic apply_request(input mma_pkg::t_in_item w);
        int row;
        int col;
        int idx;
        row = int'(w.row_index);
        col = int'(w.col_index);
        idx = row * mma_pkg::MAX_DIM + col;
        case (w.req_type)
            mma_pkg::REQ_WR_A: begin
                a_store[idx] = w.elem_value[mma_pkg::AB_W-1:0];
            end
            mma_pkg::REQ_WR_B: begin
                b_store[idx] = w.elem_value[mma_pkg::AB_W-1:0];
            end
            mma_pkg::REQ_WR_C: begin
                c_store[idx] = w.elem_value;
            end
            default: begin
                if (row < order_of(cfg_shadow.matrix_size) &&
                    col < order_of(cfg_shadow.matrix_size)) begin
                    c_elem_queue.push_back(gemm_element(row, col));
                end
            end
        endcase
    endtask

    // Driver: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                apply_request(in_word);
            end
            if (!in_valid || o_in_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_word <= request_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-off when armed, random stalls otherwise
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_OFF_LEN - 1;
            hold_served <= hold_requests;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : monitor
        mma_pkg::t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (c_elem_queue.size() == 0) begin
                $error("unexpected result word: result_value %0d saturated %0b",
                       o_out_data.result_value, o_out_data.saturated);
                mismatches++;
            end else begin
                want = c_elem_queue.pop_front();
                if (o_out_data.result_value !== want.result_value) begin
                    $error("result_value expected %0d actual %0d",
                           want.result_value, o_out_data.result_value);
                    mismatches++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $error("saturated expected %0b actual %0b",
                           want.saturated, o_out_data.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Write one register over the configuration port, junk in the unused upper bits
    task automatic apb_write(input logic [1:0] index,
                             input logic [mma_pkg::GAIN_W-1:0] value);
        logic [mma_pkg::DATA_W-1:0] data;
        data = $urandom;
        case (index)
            mma_pkg::REG_SIZE: begin
                data[mma_pkg::SIZE_W-1:0] = value[mma_pkg::SIZE_W-1:0];
            end
            default: begin
                data[mma_pkg::GAIN_W-1:0] = value;
            end
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            mma_pkg::REG_SIZE:  cfg_shadow.matrix_size = data[mma_pkg::SIZE_W-1:0];
            mma_pkg::REG_ALPHA: cfg_shadow.alpha_gain = data[mma_pkg::GAIN_W-1:0];
            default:            cfg_shadow.beta_gain = data[mma_pkg::GAIN_W-1:0];
        endcase
        gen_order = order_of(cfg_shadow.matrix_size);
    endtask

    task automatic set_config(input logic [mma_pkg::SIZE_W-1:0] size,
                              input logic [mma_pkg::GAIN_W-1:0] alpha,
                              input logic [mma_pkg::GAIN_W-1:0] beta);
        apb_write(mma_pkg::REG_SIZE, mma_pkg::GAIN_W'(size));
        apb_write(mma_pkg::REG_ALPHA, alpha);
        apb_write(mma_pkg::REG_BETA, beta);
        @(negedge i_clk);
    endtask

    // Queue one request word and note which store entry it loads
    task automatic push_request(input mma_pkg::t_req kind, input int row, input int col,
                                input logic [mma_pkg::ELEM_W-1:0] value);
        mma_pkg::t_in_item w;
        w.req_type = kind;
        w.row_index = mma_pkg::IDX_W'(row);
        w.col_index = mma_pkg::IDX_W'(col);
        w.elem_value = value;
        case (kind)
            mma_pkg::REQ_WR_A: a_loaded[row * mma_pkg::MAX_DIM + col] = 1'b1;
            mma_pkg::REQ_WR_B: b_loaded[row * mma_pkg::MAX_DIM + col] = 1'b1;
            mma_pkg::REQ_WR_C: c_loaded[row * mma_pkg::MAX_DIM + col] = 1'b1;
            default: ;
        endcase
        request_queue.push_back(w);
    endtask

    // Mix of full random, small signed and extreme element values
    function automatic logic [mma_pkg::ELEM_W-1:0] rand_elem();
        logic [mma_pkg::ELEM_W-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: ;
            1: v = {{23{v[9]}}, v[8:0]};
            2: v[mma_pkg::AB_W-1:0] = v[16] ? 16'h7FFF : 16'h8000;
            default: v = v[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        return v;
    endfunction

    // Random words: mostly loads followed by an in-range compute, plus stray writes and stray computes
    task automatic gen_random(input int count);
        int made;
        int roll;
        int row;
        int col;
        made = 0;
        while (made < count) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
                push_request(mma_pkg::t_req'($urandom_range(int'(mma_pkg::REQ_WR_C))),
                             $urandom_range(mma_pkg::MAX_DIM - 1),
                             $urandom_range(mma_pkg::MAX_DIM - 1), rand_elem());
                made++;
            end else begin
                if (roll < 85) begin
                    row = $urandom_range(gen_order - 1);
                    col = $urandom_range(gen_order - 1);
                end else begin
                    row = $urandom_range(mma_pkg::MAX_DIM - 1);
                    col = $urandom_range(mma_pkg::MAX_DIM - 1);
                end
                if (row < gen_order && col < gen_order) begin
                    // fill any operand the compute would read that was never loaded
                    for (int k = 0; k < gen_order; k++) begin
                        if (!a_loaded[row * mma_pkg::MAX_DIM + k]) begin
                            push_request(mma_pkg::REQ_WR_A, row, k, rand_elem());
                            made++;
                        end
                        if (!b_loaded[k * mma_pkg::MAX_DIM + col]) begin
                            push_request(mma_pkg::REQ_WR_B, k, col, rand_elem());
                            made++;
                        end
                    end
                    if (!c_loaded[row * mma_pkg::MAX_DIM + col]) begin
                        push_request(mma_pkg::REQ_WR_C, row, col, rand_elem());
                        made++;
                    end
                end
                push_request(mma_pkg::REQ_COMPUTE, row, col, $urandom);
                made++;
            end
        end
    endtask

    // Hold until every word is in and every result is out, then let the block settle
    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || c_elem_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [mma_pkg::SIZE_W-1:0] size,
                             input logic [mma_pkg::GAIN_W-1:0] alpha,
                             input logic [mma_pkg::GAIN_W-1:0] beta, input int send_pct,
                             input int recv_pct, input int count, input bit hold_off);
        wait_drained();
        set_config(size, alpha, beta);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        gen_random(count);
        if (hold_off) begin
            hold_requests++;
        end
    endtask

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("matrix_multiply_accumulate verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < mma_pkg::DEPTH; i++) begin
            a_store[i] = '0;
            b_store[i] = '0;
            c_store[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // Order 2 with the reset gains: operand extremes, upper bits of A and B ignored
        apb_write(mma_pkg::REG_SIZE, mma_pkg::GAIN_W'(2));
        @(negedge i_clk);
        push_request(mma_pkg::REQ_WR_A, 0, 0, 32'hFFFF_7FFF);
        push_request(mma_pkg::REQ_WR_A, 0, 1, 32'h0000_8000);
        push_request(mma_pkg::REQ_WR_A, 1, 0, 32'h1234_0000);
        push_request(mma_pkg::REQ_WR_A, 1, 1, 32'hFFFF_FFFF);
        push_request(mma_pkg::REQ_WR_B, 0, 0, 32'h5A5A_7FFF);
        push_request(mma_pkg::REQ_WR_B, 1, 0, 32'h0000_8000);
        push_request(mma_pkg::REQ_WR_B, 0, 1, 32'h0000_0001);
        push_request(mma_pkg::REQ_WR_B, 1, 1, 32'hA5A5_8000);
        push_request(mma_pkg::REQ_WR_C, 0, 0, 32'h7FFF_FFFF);
        push_request(mma_pkg::REQ_WR_C, 1, 1, 32'h8000_0000);
        push_request(mma_pkg::REQ_COMPUTE, 0, 0, 32'h0);
        push_request(mma_pkg::REQ_COMPUTE, 1, 1, 32'hFFFF_FFFF);
        // computes outside the order in use give no word
        push_request(mma_pkg::REQ_COMPUTE, 2, 0, 32'h0);
        push_request(mma_pkg::REQ_COMPUTE, 0, 15, 32'h0);
        push_request(mma_pkg::REQ_COMPUTE, 15, 15, 32'h0);
        push_request(mma_pkg::REQ_WR_A, 15, 15, 32'h8000_0000);
        push_request(mma_pkg::REQ_WR_B, 15, 15, 32'h7FFF_FFFF);
        push_request(mma_pkg::REQ_WR_C, 15, 15, 32'hFFFF_FFFF);

        // Largest gains, then most negative gains: each setting clips one element high and the other low
        wait_drained();
        set_config(2, 16'h7FFF, 16'h7FFF);
        push_request(mma_pkg::REQ_COMPUTE, 0, 0, 32'h0);
        push_request(mma_pkg::REQ_COMPUTE, 1, 1, 32'h0);
        wait_drained();
        set_config(2, 16'h8000, 16'h8000);
        push_request(mma_pkg::REQ_COMPUTE, 0, 0, 32'h0);
        push_request(mma_pkg::REQ_COMPUTE, 1, 1, 32'h0);

        // Random phases over orders, gains and idling patterns
        run_phase(1, 16'd4096, 16'd4096, 0, 0, 120, 1'b0);
        run_phase(3, 16'($urandom), 16'($urandom), 55, 0, 140, 1'b0);
        run_phase(0, 16'h8000, 16'h7FFF, 0, 55, 130, 1'b0);
        run_phase(31, 16'd4096, 16'd0, 31, 31, 140, 1'b0);
        run_phase(4, 16'h7FFF, 16'h8000, 0, 0, 130, 1'b1);
        run_phase(16, 16'($urandom), 16'($urandom), 55, 0, 100, 1'b0);
        run_phase(mma_pkg::SIZE_W'($urandom_range(8, 1)), 16'($urandom), 16'($urandom),
                  31, 31, 150, 1'b0);
        run_phase(2, 16'd0, 16'($urandom), 0, 55, 120, 1'b0);
        run_phase(mma_pkg::SIZE_W'($urandom_range(6, 1)), 16'($urandom), 16'($urandom),
                  0, 0, 120, 1'b0);

        wait_drained();
        if (mismatches == 0 && c_elem_queue.size() == 0) begin
            $display("matrix_multiply_accumulate verification clean");
        end else begin
            $display("matrix_multiply_accumulate verification failed");
        end
        $finish;
    end

endmodule
